// ----- rtl/biquad_cascade_eq_limiter_core_assert.svh -----
// Assertion macros for the equalizer core.
`ifndef BIQUAD_CASCADE_EQ_LIMITER_CORE_ASSERT_SVH
`define BIQUAD_CASCADE_EQ_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BQEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqeq check failed");

// Next-cycle implication.
`define BQEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqeq check failed");

`endif

// ----- rtl/bqeq_pkg.sv -----
package bqeq_pkg;

   localparam int NUM_BANDS_DEF    = 32;
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int NUM_SLOTS        = 5;

   localparam logic [31:0] COEF_ONE = 32'h0400_0000;

   localparam logic        EQ_EN_RST     = 1'b1;
   localparam logic [3:0]  CHAN_CNT_RST  = 4'd2;
   localparam logic [5:0]  BAND_CNT_RST  = 6'd20;
   localparam logic [23:0] GAIN_RST      = 24'd2097152;
   localparam logic [23:0] CEIL_RST      = 24'd8388608;
   localparam logic [23:0] CEIL_ONE      = 24'd8388608;
   localparam logic [23:0] CEIL_POS_MAX  = 24'd8388607;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_COEF   = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_EQ_EN    = 3'd0,
      CSR_CHAN_CNT = 3'd1,
      CSR_BAND_CNT = 3'd2,
      CSR_GAIN     = 3'd3,
      CSR_CEIL     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_BAND,
      ST_PRE_MUL,
      ST_PRE_LIM,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctl_type;

endpackage

// ----- rtl/bqeq_ram.sv -----
module bqeq_ram #(
   parameter int DEPTH = 160,
   parameter int AW    = 8,
   parameter int W     = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata_ff
);

   logic [W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

// ----- rtl/bqeq_mac.sv -----
module bqeq_mac (
   input  logic                 clock,
   input  bqeq_pkg::mac_ctl_type ctl,
   input  logic signed [31:0]   mul_a,
   input  logic signed [31:0]   mul_b,
   output logic signed [63:0]   prod_ff,
   output logic signed [31:0]   y
);

   logic signed [63:0] prod_in;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [63:0] term;
   logic signed [63:0] rnd;
   logic signed [63:0] sh;

   always_comb begin
      prod_in = ctl.mul_en ? (mul_a * mul_b) : prod_ff;
      term    = prod_ff >>> 4;
      case (ctl.acc_op)
         bqeq_pkg::ACC_LOAD: acc_in = term;
         bqeq_pkg::ACC_ADD:  acc_in = acc_ff + term;
         bqeq_pkg::ACC_SUB:  acc_in = acc_ff - term;
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round to Q8.23 and saturate
   always_comb begin
      rnd = acc_ff + 64'sd2097152;
      sh  = rnd >>> 22;
      if (sh > 64'sd2147483647) begin
         y = 32'sh7FFF_FFFF;
      end else if (sh < -64'sd2147483648) begin
         y = 32'sh8000_0000;
      end else begin
         y = sh[31:0];
      end
   end

endmodule

// ----- rtl/biquad_cascade_eq_limiter_core.sv -----
// Sample item: runs bands = min(band_count, NUM_BANDS) biquad sections, then preamp and limiter.
// Each band steps through the single shared 32x32 multiplier-accumulator.
// Passthrough and count read go straight to ST_EMIT, which raises rsp_tvalid once the output
// register is free. Coefficient write: the RAM is written on accept.
// One item at a time, req_tready high only while idle. Reset (sync, active high): a sweep
// initializes coefficients and history; a history clear item reruns the history sweep.
module biquad_cascade_eq_limiter_core #(
   parameter int NUM_BANDS    = bqeq_pkg::NUM_BANDS_DEF,
   parameter int NUM_CHANNELS = bqeq_pkg::NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // channel[2:0], sample[26:3], coef_band[31:27], coef_slot[34:32], coef_value[66:35]
   input  logic [bqeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_sample[23:0], out_channel[26:24], clipped[27], clamp_count[59:28]
   output logic [bqeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int COEF_DEPTH = NUM_BANDS * bqeq_pkg::NUM_SLOTS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int HIST_ROWS  = NUM_CHANNELS * NUM_BANDS;
   localparam int HIST_AW    = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
   localparam int SWEEP_LEN  = (HIST_ROWS > COEF_DEPTH) ? HIST_ROWS : COEF_DEPTH;
   localparam int SWEEP_W    = $clog2(SWEEP_LEN + 1);
   localparam int BAND_W     = $clog2(NUM_BANDS + 1);

   logic        eq_en_ff;
   logic [3:0]  chan_cnt_ff;
   logic [5:0]  band_cnt_ff;
   logic [23:0] gain_ff;
   logic [23:0] ceil_ff;

   bqeq_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [BAND_W-1:0]   band_ff, band_in;
   logic [BAND_W-1:0]   bands_ff, bands_in;
   logic signed [31:0]  x_ff, x_in;
   logic [COEF_AW-1:0]  coef_addr_ff, coef_addr_in;
   logic [HIST_AW-1:0]  hist_addr_ff, hist_addr_in;
   logic [SWEEP_W-1:0]  sweep_ff, sweep_in;
   logic [2:0]          sweep_slot_ff, sweep_slot_in;
   logic                init_ff, init_in;
   logic [31:0]         cnt_ff, cnt_in;
   logic [23:0]         res_sample_ff, res_sample_in;
   logic [2:0]          res_ch_ff, res_ch_in;
   logic                res_clip_ff, res_clip_in;
   logic                cnt_read_ff, cnt_read_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [bqeq_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [2:0]  req_ch;
   logic [23:0] req_sample;
   logic [4:0]  req_band;
   logic [2:0]  req_slot;
   logic [31:0] req_coef;
   bqeq_pkg::func_type req_func;

   logic              req_acc;
   logic              out_free;
   logic [4:0]        chans_eff;
   logic              ch_ok;
   logic [6:0]        bands_eff7;
   logic [BAND_W-1:0] bands_eff;
   logic              sweep_last;

   logic               coef_we;
   logic [COEF_AW-1:0] coef_waddr;
   logic [31:0]        coef_wdata;
   logic               coef_re;
   logic [31:0]        coef_rdata;
   logic               hist_we;
   logic [HIST_AW-1:0] hist_waddr;
   logic [127:0]       hist_wdata;
   logic               hist_re;
   logic [127:0]       hist_rdata;

   bqeq_pkg::mac_ctl_type mac_ctl;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic signed [31:0] mac_y;

   logic signed [63:0] p_full;
   logic [23:0]        c_lo, c_hi;
   logic signed [63:0] c_pos, c_neg;
   logic               lim_clip;
   logic [23:0]        lim_val;

   assign req_ch     = req_tdata[2:0];
   assign req_sample = req_tdata[26:3];
   assign req_band   = req_tdata[31:27];
   assign req_slot   = req_tdata[34:32];
   assign req_coef   = req_tdata[66:35];
   assign req_func   = bqeq_pkg::func_type'(req_tuser);

   assign req_tready = (state_ff == bqeq_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign sweep_last = (sweep_ff == SWEEP_W'(SWEEP_LEN - 1));

   always_comb begin
      if (chan_cnt_ff == 4'd0) begin
         chans_eff = 5'd1;
      end else if ({1'b0, chan_cnt_ff} > 5'(NUM_CHANNELS)) begin
         chans_eff = 5'(NUM_CHANNELS);
      end else begin
         chans_eff = {1'b0, chan_cnt_ff};
      end
      ch_ok = ({2'b00, req_ch} < chans_eff);
      bands_eff7 = ({1'b0, band_cnt_ff} > 7'(NUM_BANDS)) ? 7'(NUM_BANDS)
                                                         : {1'b0, band_cnt_ff};
      bands_eff = BAND_W'(bands_eff7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_en_ff    <= bqeq_pkg::EQ_EN_RST;
         chan_cnt_ff <= bqeq_pkg::CHAN_CNT_RST;
         band_cnt_ff <= bqeq_pkg::BAND_CNT_RST;
         gain_ff     <= bqeq_pkg::GAIN_RST;
         ceil_ff     <= bqeq_pkg::CEIL_RST;
      end else if (csr_we) begin
         case (bqeq_pkg::csr_index_type'(csr_addr))
            bqeq_pkg::CSR_EQ_EN:    eq_en_ff    <= csr_wdata[0];
            bqeq_pkg::CSR_CHAN_CNT: chan_cnt_ff <= csr_wdata[3:0];
            bqeq_pkg::CSR_BAND_CNT: band_cnt_ff <= csr_wdata[5:0];
            bqeq_pkg::CSR_GAIN:     gain_ff     <= csr_wdata;
            bqeq_pkg::CSR_CEIL:     ceil_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // preamp rounding and limiter
   always_comb begin
      p_full   = (prod + 64'sd1048576) >>> 21;
      c_lo     = (ceil_ff > bqeq_pkg::CEIL_ONE) ? bqeq_pkg::CEIL_ONE : ceil_ff;
      c_hi     = (c_lo > bqeq_pkg::CEIL_POS_MAX) ? bqeq_pkg::CEIL_POS_MAX : c_lo;
      c_pos    = $signed({40'd0, c_hi});
      c_neg    = -$signed({40'd0, c_lo});
      lim_clip = 1'b1;
      if (p_full > c_pos) begin
         lim_val = c_hi;
      end else if (p_full < c_neg) begin
         lim_val = c_neg[23:0];
      end else begin
         lim_val  = p_full[23:0];
         lim_clip = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqeq_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_func)
                  bqeq_pkg::FUNC_SAMPLE: begin
                     if (!ch_ok) begin
                        state_in = bqeq_pkg::ST_IDLE;
                     end else if (!eq_en_ff) begin
                        state_in = bqeq_pkg::ST_EMIT;
                     end else if (bands_eff == '0) begin
                        state_in = bqeq_pkg::ST_PRE_MUL;
                     end else begin
                        state_in = bqeq_pkg::ST_BAND;
                     end
                  end
                  bqeq_pkg::FUNC_READ:  state_in = bqeq_pkg::ST_EMIT;
                  bqeq_pkg::FUNC_CLEAR: state_in = bqeq_pkg::ST_CLEAR;
                  default:              state_in = bqeq_pkg::ST_IDLE;
               endcase
            end
         end
         bqeq_pkg::ST_CLEAR: begin
            if (sweep_last) begin
               state_in = bqeq_pkg::ST_IDLE;
            end
         end
         bqeq_pkg::ST_BAND: begin
            if (step_ff == 3'd7 && band_ff == bands_ff - BAND_W'(1)) begin
               state_in = bqeq_pkg::ST_PRE_MUL;
            end
         end
         bqeq_pkg::ST_PRE_MUL: state_in = bqeq_pkg::ST_PRE_LIM;
         bqeq_pkg::ST_PRE_LIM: state_in = bqeq_pkg::ST_EMIT;
         bqeq_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = bqeq_pkg::ST_IDLE;
            end
         end
         default: state_in = bqeq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in       = step_ff;
      band_in       = band_ff;
      bands_in      = bands_ff;
      x_in          = x_ff;
      coef_addr_in  = coef_addr_ff;
      hist_addr_in  = hist_addr_ff;
      sweep_in      = sweep_ff;
      sweep_slot_in = sweep_slot_ff;
      init_in       = init_ff;
      cnt_in        = cnt_ff;
      res_sample_in = res_sample_ff;
      res_ch_in     = res_ch_ff;
      res_clip_in   = res_clip_ff;
      cnt_read_in   = cnt_read_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      coef_we       = 1'b0;
      coef_waddr    = COEF_AW'(req_band * bqeq_pkg::NUM_SLOTS + req_slot);
      coef_wdata    = req_coef;
      coef_re       = 1'b0;
      hist_we       = 1'b0;
      hist_waddr    = hist_addr_ff;
      hist_wdata    = {hist_rdata[95:64], mac_y, hist_rdata[31:0], x_ff};
      hist_re       = 1'b0;
      mac_ctl       = '{mul_en: 1'b0, acc_op: bqeq_pkg::ACC_HOLD};
      mul_a         = $signed(coef_rdata);
      mul_b         = x_ff;

      case (state_ff)
         bqeq_pkg::ST_IDLE: begin
            if (req_acc) begin
               x_in          = $signed({{8{req_sample[23]}}, req_sample});
               hist_addr_in  = HIST_AW'(req_ch * NUM_BANDS);
               coef_addr_in  = '0;
               band_in       = '0;
               step_in       = 3'd0;
               bands_in      = bands_eff;
               res_ch_in     = req_ch;
               res_sample_in = req_sample;
               res_clip_in   = 1'b0;
               cnt_read_in   = (req_func == bqeq_pkg::FUNC_READ);
               if (req_func == bqeq_pkg::FUNC_READ) begin
                  res_ch_in     = 3'd0;
                  res_sample_in = 24'd0;
               end
               if (req_func == bqeq_pkg::FUNC_CLEAR) begin
                  sweep_in      = '0;
                  sweep_slot_in = 3'd0;
                  init_in       = 1'b0;
               end
               if (req_func == bqeq_pkg::FUNC_COEF &&
                   32'(req_band) < 32'(NUM_BANDS) &&
                   req_slot < 3'(bqeq_pkg::NUM_SLOTS)) begin
                  coef_we = 1'b1;
               end
            end
         end
         bqeq_pkg::ST_CLEAR: begin
            sweep_in      = sweep_ff + SWEEP_W'(1);
            sweep_slot_in = (sweep_slot_ff == 3'(bqeq_pkg::NUM_SLOTS - 1)) ? 3'd0
                                                                          : sweep_slot_ff + 3'd1;
            if (init_ff && 32'(sweep_ff) < 32'(COEF_DEPTH)) begin
               coef_we    = 1'b1;
               coef_waddr = COEF_AW'(sweep_ff);
               coef_wdata = (sweep_slot_ff == 3'd0) ? bqeq_pkg::COEF_ONE : 32'd0;
            end
            if (32'(sweep_ff) < 32'(HIST_ROWS)) begin
               hist_we    = 1'b1;
               hist_waddr = HIST_AW'(sweep_ff);
               hist_wdata = '0;
            end
         end
         bqeq_pkg::ST_BAND: begin
            step_in = step_ff + 3'd1;
            if (step_ff <= 3'd4) begin
               coef_re      = 1'b1;
               coef_addr_in = coef_addr_ff + COEF_AW'(1);
            end
            hist_re = (step_ff == 3'd0);
            case (step_ff)
               3'd1: mac_ctl.mul_en = 1'b1;
               3'd2: begin
                  mac_ctl = '{mul_en: 1'b1, acc_op: bqeq_pkg::ACC_LOAD};
                  mul_b   = $signed(hist_rdata[31:0]);
               end
               3'd3: begin
                  mac_ctl = '{mul_en: 1'b1, acc_op: bqeq_pkg::ACC_ADD};
                  mul_b   = $signed(hist_rdata[63:32]);
               end
               3'd4: begin
                  mac_ctl = '{mul_en: 1'b1, acc_op: bqeq_pkg::ACC_ADD};
                  mul_b   = $signed(hist_rdata[95:64]);
               end
               3'd5: begin
                  mac_ctl = '{mul_en: 1'b1, acc_op: bqeq_pkg::ACC_SUB};
                  mul_b   = $signed(hist_rdata[127:96]);
               end
               3'd6: mac_ctl.acc_op = bqeq_pkg::ACC_SUB;
               3'd7: begin
                  hist_we      = 1'b1;
                  x_in         = mac_y;
                  hist_addr_in = hist_addr_ff + HIST_AW'(1);
                  band_in      = band_ff + BAND_W'(1);
               end
               default: ;
            endcase
         end
         bqeq_pkg::ST_PRE_MUL: begin
            mac_ctl.mul_en = 1'b1;
            mul_a          = x_ff;
            mul_b          = $signed({8'd0, gain_ff});
         end
         bqeq_pkg::ST_PRE_LIM: begin
            res_sample_in = lim_val;
            res_clip_in   = lim_clip;
            if (lim_clip && cnt_ff != 32'hFFFF_FFFF) begin
               cnt_in = cnt_ff + 32'd1;
            end
         end
         bqeq_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'd0, (cnt_read_ff ? cnt_ff : 32'd0), res_clip_ff,
                                res_ch_ff, res_sample_ff};
               if (cnt_read_ff) begin
                  cnt_in = 32'd0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bqeq_pkg::ST_CLEAR;
         sweep_ff      <= '0;
         sweep_slot_ff <= 3'd0;
         init_ff       <= 1'b1;
         cnt_ff        <= 32'd0;
         rsp_tvalid_ff <= 1'b0;
         step_ff       <= 3'd0;
         band_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sweep_slot_ff <= sweep_slot_in;
         init_ff       <= init_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         step_ff       <= step_in;
         band_ff       <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      bands_ff      <= bands_in;
      x_ff          <= x_in;
      coef_addr_ff  <= coef_addr_in;
      hist_addr_ff  <= hist_addr_in;
      res_sample_ff <= res_sample_in;
      res_ch_ff     <= res_ch_in;
      res_clip_ff   <= res_clip_in;
      cnt_read_ff   <= cnt_read_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   bqeq_ram #(
      .DEPTH (COEF_DEPTH),
      .AW    (COEF_AW),
      .W     (32)
   ) u_coef_ram (
      .clock    (clock),
      .we       (coef_we),
      .waddr    (coef_waddr),
      .wdata    (coef_wdata),
      .re       (coef_re),
      .raddr    (coef_addr_ff),
      .rdata_ff (coef_rdata)
   );

   bqeq_ram #(
      .DEPTH (HIST_ROWS),
      .AW    (HIST_AW),
      .W     (128)
   ) u_hist_ram (
      .clock    (clock),
      .we       (hist_we),
      .waddr    (hist_waddr),
      .wdata    (hist_wdata),
      .re       (hist_re),
      .raddr    (hist_addr_ff),
      .rdata_ff (hist_rdata)
   );

   bqeq_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod),
      .y       (mac_y)
   );

`include "biquad_cascade_eq_limiter_core_assert.svh"

   `BQEQ_ASSERT_IMPL(a_band_range, clock, reset, state_ff == bqeq_pkg::ST_BAND,
                     band_ff < bands_ff)
   `BQEQ_ASSERT_NEXT(a_count_mono, clock, reset,
                     !(state_ff == bqeq_pkg::ST_EMIT && cnt_read_ff),
                     cnt_ff >= $past(cnt_ff))
   `BQEQ_ASSERT_NEXT(a_clip_counts, clock, reset,
                     state_ff == bqeq_pkg::ST_PRE_LIM && lim_clip, cnt_ff != 32'd0)

endmodule

// ----- verif/eq_response_checker.sv -----
module eq_response_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [bqeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [bqeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [2:0]                       csr_addr,
   input  logic [23:0]                      csr_wdata,
   output int                               errors,
   output int                               pending,
   output int                               samples_seen,
   output int                               clamps_seen,
   output int                               reads_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = bqeq_pkg::NUM_BANDS_DEF;
   localparam int NC = bqeq_pkg::NUM_CHANNELS_DEF;
   localparam int NS = bqeq_pkg::NUM_SLOTS;

   typedef struct {
      logic [23:0] smp;
      logic [2:0]  chan;
      logic        clip;
      logic [31:0] count;
   } eq_output_type;

   eq_output_type pending_outputs[$];
   logic          eq_en;
   logic [3:0]    chan_cnt;
   logic [5:0]    band_cnt;
   logic [23:0]   gain;
   logic [23:0]   ceiling;
   int            coefs[NB*NS];
   int            hist[NC*NB*4];
   logic [31:0]   clamp_cnt;

   function automatic longint run_band(int ch, int b, longint x);
      longint acc;
      longint y;
      int     c0, h;
      c0 = b * NS;
      h = (ch * NB + b) * 4;
      acc = (longint'(coefs[c0]) * x) >>> 4;
      acc += (longint'(coefs[c0+1]) * longint'(hist[h])) >>> 4;
      acc += (longint'(coefs[c0+2]) * longint'(hist[h+1])) >>> 4;
      acc -= (longint'(coefs[c0+3]) * longint'(hist[h+2])) >>> 4;
      acc -= (longint'(coefs[c0+4]) * longint'(hist[h+3])) >>> 4;
      y = (acc + (longint'(1) << 21)) >>> 22;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      hist[h+1] = hist[h];
      hist[h] = int'(x);
      hist[h+3] = hist[h+2];
      hist[h+2] = int'(y);
      return y;
   endfunction

   task automatic predict_item(logic [1:0] fn, logic [bqeq_pkg::REQ_TDATA_W-1:0] d);
      eq_output_type o;
      int            chans, bands, ch;
      longint        x, p, lo, hi, lim;
      ch = int'(d[2:0]);
      case (bqeq_pkg::func_type'(fn))
         bqeq_pkg::FUNC_SAMPLE: begin
            chans = int'(chan_cnt);
            if (chans < 1) chans = 1;
            if (chans > NC) chans = NC;
            if (ch < chans) begin
               o.chan = d[2:0];
               o.count = '0;
               o.clip = 1'b0;
               if (!eq_en) begin
                  o.smp = d[26:3];
               end else begin
                  x = longint'($signed(d[26:3]));
                  bands = int'(band_cnt);
                  if (bands > NB) bands = NB;
                  for (int b = 0; b < bands; b++) x = run_band(ch, b, x);
                  p = (x * longint'({40'd0, gain}) + (longint'(1) << 20)) >>> 21;
                  lo = longint'(ceiling);
                  if (lo > 8388608) lo = 8388608;
                  hi = (lo > 8388607) ? 8388607 : lo;
                  lim = p;
                  if (lim < -lo) lim = -lo;
                  if (lim > hi) lim = hi;
                  if (lim != p) begin
                     o.clip = 1'b1;
                     clamps_seen++;
                     if (clamp_cnt != 32'hFFFF_FFFF) clamp_cnt++;
                  end
                  o.smp = lim[23:0];
               end
               samples_seen++;
               pending_outputs.push_back(o);
            end
         end
         bqeq_pkg::FUNC_COEF: begin
            if (d[34:32] <= 3'd4)
               coefs[int'(d[31:27]) * NS + int'(d[34:32])] = int'(d[66:35]);
         end
         bqeq_pkg::FUNC_READ: begin
            o.smp = '0;
            o.chan = '0;
            o.clip = 1'b0;
            o.count = clamp_cnt;
            clamp_cnt = '0;
            reads_seen++;
            pending_outputs.push_back(o);
         end
         default: begin
            foreach (hist[i]) hist[i] = 0;
         end
      endcase
   endtask

   task automatic compare_output(logic [bqeq_pkg::RSP_TDATA_W-1:0] d);
      eq_output_type e;
      if (pending_outputs.size() == 0) begin
         errors++;
         $display("%0t: unexpected output, expected none, actual %h", $time, d);
         return;
      end
      e = pending_outputs.pop_front();
      if (d[23:0] !== e.smp) begin
         errors++;
         $display("%0t: out_sample expected %h actual %h", $time, e.smp, d[23:0]);
      end
      if (d[26:24] !== e.chan) begin
         errors++;
         $display("%0t: out_channel expected %0d actual %0d", $time, e.chan, d[26:24]);
      end
      if (d[27] !== e.clip) begin
         errors++;
         $display("%0t: clipped expected %0d actual %0d", $time, e.clip, d[27]);
      end
      if (d[59:28] !== e.count) begin
         errors++;
         $display("%0t: clamp_count expected %0d actual %0d", $time, e.count, d[59:28]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         eq_en = bqeq_pkg::EQ_EN_RST;
         chan_cnt = bqeq_pkg::CHAN_CNT_RST;
         band_cnt = bqeq_pkg::BAND_CNT_RST;
         gain = bqeq_pkg::GAIN_RST;
         ceiling = bqeq_pkg::CEIL_RST;
         foreach (coefs[i]) coefs[i] = (i % NS == 0) ? int'(bqeq_pkg::COEF_ONE) : 0;
         foreach (hist[i]) hist[i] = 0;
         clamp_cnt = '0;
         pending_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_output(rsp_tdata);
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         if (csr_we) begin
            case (bqeq_pkg::csr_index_type'(csr_addr))
               bqeq_pkg::CSR_EQ_EN:    eq_en = csr_wdata[0];
               bqeq_pkg::CSR_CHAN_CNT: chan_cnt = csr_wdata[3:0];
               bqeq_pkg::CSR_BAND_CNT: band_cnt = csr_wdata[5:0];
               bqeq_pkg::CSR_GAIN:     gain = csr_wdata;
               bqeq_pkg::CSR_CEIL:     ceiling = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = pending_outputs.size();
   end

endmodule

// ----- verif/tb_biquad_cascade_eq_limiter_core.sv -----
module tb_biquad_cascade_eq_limiter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 600;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bqeq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]                       req_tuser = bqeq_pkg::FUNC_SAMPLE;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bqeq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [2:0]                       csr_addr = bqeq_pkg::CSR_EQ_EN;
   logic [23:0]                      csr_wdata = '0;

   int errors, pending, samples_seen, clamps_seen, reads_seen;
   int items_sent = 0;
   int idle_cycles = 0;
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   bit hold_req = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   biquad_cascade_eq_limiter_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   eq_response_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .samples_seen(samples_seen),
      .clamps_seen(clamps_seen), .reads_seen(reads_seen)
   );

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int k;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         k = rsp_gaps ? int'($urandom_range(0, 15)) : 0;
         if (k > 0) begin
            rsp_tready <= 1'b0;
            repeat (k) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [bqeq_pkg::REQ_TDATA_W-1:0] pack_item(logic [2:0] ch,
         logic [23:0] smp, logic [4:0] band, logic [2:0] slot, logic [31:0] val);
      return {5'd0, val, slot, band, smp, ch};
   endfunction

   task automatic send_item(bqeq_pkg::func_type fn, logic [bqeq_pkg::REQ_TDATA_W-1:0] d);
      int k;
      k = req_gaps ? int'($urandom_range(0, 15)) : 0;
      if (k > 0) begin
         req_tvalid <= 1'b0;
         repeat (k) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic en, logic [3:0] ch, logic [5:0] bands, logic [23:0] g,
         logic [23:0] c);
      wait_drained();
      csr_we <= 1'b1;
      csr_addr <= bqeq_pkg::CSR_EQ_EN;    csr_wdata <= {23'd0, en};    @(posedge clock);
      csr_addr <= bqeq_pkg::CSR_CHAN_CNT; csr_wdata <= {20'd0, ch};    @(posedge clock);
      csr_addr <= bqeq_pkg::CSR_BAND_CNT; csr_wdata <= {18'd0, bands}; @(posedge clock);
      csr_addr <= bqeq_pkg::CSR_GAIN;     csr_wdata <= g;              @(posedge clock);
      csr_addr <= bqeq_pkg::CSR_CEIL;     csr_wdata <= c;              @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(logic [2:0] ch, logic [23:0] smp);
      send_item(bqeq_pkg::FUNC_SAMPLE, pack_item(ch, smp, 5'($urandom), 3'($urandom),
                                                 32'($urandom)));
   endtask

   task automatic send_coef(logic [4:0] band, logic [2:0] slot, logic [31:0] val);
      send_item(bqeq_pkg::FUNC_COEF, pack_item(3'($urandom), 24'($urandom), band, slot, val));
   endtask

   task automatic send_ctrl(bqeq_pkg::func_type fn);
      send_item(fn, pack_item(3'($urandom), 24'($urandom), 5'($urandom), 3'($urandom),
                              32'($urandom)));
   endtask

   task automatic send_random_item();
      int r;
      logic [2:0] slot;
      logic [31:0] val;
      r = int'($urandom_range(0, 99));
      if (r < 72) begin
         case ($urandom_range(0, 5))
            0: send_sample(3'($urandom), 24'h7FFFFF);
            1: send_sample(3'($urandom), 24'h800000);
            default: send_sample(3'($urandom_range(0, 7)), 24'($urandom));
         endcase
      end else if (r < 88) begin
         slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         case (slot)
            3'd0: val = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            3'd3: val = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            default: val = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         endcase
         if ($urandom_range(0, 7) == 0) val = $urandom;
         send_coef(5'($urandom), slot, val);
      end else if (r < 97) begin
         send_ctrl(bqeq_pkg::FUNC_READ);
      end else begin
         send_ctrl(bqeq_pkg::FUNC_CLEAR);
      end
   endtask

   initial begin
      logic [5:0]  bands;
      logic [3:0]  chans;
      logic [23:0] g, c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      send_sample(3'd0, 24'h7FFFFF);
      send_sample(3'd1, 24'h800000);
      send_sample(3'd0, 24'h000000);
      send_sample(3'd7, 24'h123456);
      send_coef(5'd0, 3'd3, 32'hFE00_0000);
      send_coef(5'd1, 3'd1, 32'h0100_0000);
      send_coef(5'd31, 3'd4, 32'h8000_0000);
      send_coef(5'd2, 3'd7, 32'hFFFF_FFFF);
      send_sample(3'd0, 24'h400000);
      send_sample(3'd0, 24'hC00000);
      send_ctrl(bqeq_pkg::FUNC_READ);
      send_ctrl(bqeq_pkg::FUNC_CLEAR);
      send_sample(3'd1, 24'h200000);
      set_config(1'b1, 4'd8, 6'd32, 24'hFFFFFF, bqeq_pkg::CEIL_ONE);
      send_sample(3'd7, 24'h7FFFFF);
      send_sample(3'd3, 24'h800000);
      send_ctrl(bqeq_pkg::FUNC_READ);
      set_config(1'b1, 4'd0, 6'd63, 24'd0, 24'd0);
      send_sample(3'd0, 24'h7FFFFF);
      send_sample(3'd1, 24'h7FFFFF);
      set_config(1'b0, 4'd15, 6'd0, bqeq_pkg::GAIN_RST, 24'hFFFFFF);
      send_sample(3'd7, 24'h800001);
      set_config(1'b1, 4'd15, 6'd0, bqeq_pkg::GAIN_RST, 24'hFFFFFF);
      send_sample(3'd5, 24'h7FFFFF);
      send_ctrl(bqeq_pkg::FUNC_READ);

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 6))
            0: bands = 6'd0;
            1: bands = 6'd32;
            2: bands = 6'd63;
            default: bands = 6'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0: chans = 4'd0;
            1: chans = 4'd15;
            2: chans = 4'd8;
            default: chans = 4'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 4))
            0: g = 24'hFFFFFF;
            1: g = 24'd0;
            2: g = bqeq_pkg::GAIN_RST;
            default: g = 24'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: c = 24'd0;
            1: c = 24'hFFFFFF;
            2: c = bqeq_pkg::CEIL_ONE;
            default: c = 24'($urandom_range(0, 24'h900000));
         endcase
         set_config(ph == 5 ? 1'b0 : ($urandom_range(0, 9) != 0), chans, bands, g, c);
         req_gaps = (ph != 1);
         rsp_gaps = (ph != 2);
         for (int i = 0; i < 105; i++) begin
            if (ph == 3 && i == 20) hold_req = 1'b1;
            if (ph == 4 && i == 50) wait_drained();
            send_random_item();
         end
      end

      wait_drained();
      $display("Sent %0d items; checked %0d samples (%0d clamped) and %0d count reads",
         items_sent, samples_seen, clamps_seen, reads_seen);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bqeq_pkg.sv
rtl/bqeq_ram.sv
rtl/bqeq_mac.sv
rtl/biquad_cascade_eq_limiter_core.sv
verif/eq_response_checker.sv
verif/tb_biquad_cascade_eq_limiter_core.sv
